// File: rtl/motor_speed_pid_feedforward_defines.svh
// Assertion macros used by the motor speed controller checker.
`ifndef MOTOR_SPEED_PID_FEEDFORWARD_DEFINES_SVH
`define MOTOR_SPEED_PID_FEEDFORWARD_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MSPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MSPF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/mspf_pkg.sv
// Shared constants and types for the motor speed PID controller.
package mspf_pkg;

    localparam int unsigned TARGET_W    = 10;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned SPEED_W     = 17;
    localparam int unsigned DRIVE_W     = 9;
    localparam int unsigned ERR_W       = 19;
    localparam int unsigned INTEG_W     = 32;
    localparam int unsigned PROD_W      = 49;
    localparam int unsigned ACC_W       = 40;
    localparam int unsigned DIV_W       = 48;
    localparam int unsigned DIVISOR_W   = 16;
    localparam int unsigned DIV_CNT_W   = 5;

    localparam int unsigned TARGET_MAX  = 580;
    localparam int unsigned DRIVE_MAX   = 400;
    localparam int unsigned SPEED_NUM   = 129120;
    localparam int unsigned FF_NUM      = 174;
    localparam int unsigned FF_SHIFT    = 8;
    localparam int unsigned INTEG_DIV   = 5000;
    localparam int unsigned DERIV_DIV   = 50;

    // Dividend widths, left-justified in the divider; two bits per cycle
    localparam int unsigned SPEED_BITS  = 18;
    localparam int unsigned INTEG_BITS  = 48;
    localparam int unsigned DERIV_BITS  = 34;
    localparam logic [DIV_CNT_W-1:0] SPEED_CYCLES = DIV_CNT_W'(SPEED_BITS / 2);
    localparam logic [DIV_CNT_W-1:0] INTEG_CYCLES = DIV_CNT_W'(INTEG_BITS / 2);
    localparam logic [DIV_CNT_W-1:0] DERIV_CYCLES = DIV_CNT_W'(DERIV_BITS / 2);

    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_GAIN_P = 2'd1;
    localparam logic [1:0] REG_GAIN_I = 2'd2;
    localparam logic [1:0] REG_GAIN_D = 2'd3;

    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [DIV_CNT_W-1:0]  cycles;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_W-1:0]      quotient;
    } div_rsp_t;

endpackage

// File: rtl/mspf_div.sv
// Shared serial restoring divider, two quotient bits per cycle.
module mspf_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  mspf_pkg::div_req_t req,
    output mspf_pkg::div_rsp_t rsp
);
    import mspf_pkg::*;

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVISOR_W-1:0] rem_mid;
    logic [DIV_W-1:0]     quo_mid;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIV_W-1:0]     quo_next;

    function automatic logic [DIVISOR_W+DIV_W-1:0] div_step(
        input logic [DIVISOR_W-1:0] r,
        input logic [DIV_W-1:0]     q,
        input logic [DIVISOR_W-1:0] d
    );
        logic [DIVISOR_W:0]   t;
        logic [DIVISOR_W:0]   s;
        logic                 bit_q;
        logic [DIVISOR_W-1:0] r_out;
        t = {r, q[DIV_W-1]};
        s = t - {1'b0, d};
        bit_q = (t >= {1'b0, d});
        r_out = bit_q ? s[DIVISOR_W-1:0] : t[DIVISOR_W-1:0];
        return {r_out, q[DIV_W-2:0], bit_q};
    endfunction

    always_comb
    begin
        {rem_mid, quo_mid}   = div_step(rem_reg, quo_reg, dvs_reg);
        {rem_next, quo_next} = div_step(rem_mid, quo_mid, dvs_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            cnt_reg  <= req.cycles;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != DIV_CNT_W'(1));
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/motor_speed_pid_feedforward.sv
// Motor speed PID controller with feedforward, APB configuration, stream I/O.
// One item is in flight at a time; with an edge pair a speed division runs first,
// and a zero target goes straight to the output. Throughput is set by the shared
// two-bit-per-cycle divider (speed, integral, derivative) and the shared 17x32
// multiplier. Reset clears registers and loop state to zero.
module motor_speed_pid_feedforward
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] edge_period_us
    input  logic        s_axis_tuser,  // [0] edge_pair_seen
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [8:0] drive_level, [25:9] measured_speed
);
    import mspf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_DIV_I_GO,
        ST_DIV_I_WAIT,
        ST_DIV_D_GO,
        ST_DIV_D_WAIT,
        ST_OUT
    } state_t;

    logic [TARGET_W-1:0] target_reg;
    logic [GAIN_W-1:0]   gain_p_reg;
    logic [GAIN_W-1:0]   gain_i_reg;
    logic [GAIN_W-1:0]   gain_d_reg;

    state_t                     state_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [SPEED_W-1:0]         speed_reg;
    logic signed [ERR_W-1:0]    diff_reg;
    logic signed [ERR_W-1:0]    dd_reg;
    logic signed [ERR_W-1:0]    prev_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       neg_reg;
    logic                       m_valid_reg;
    logic [DRIVE_W+SPEED_W-1:0] m_data_reg;

    logic                       wr_en;
    logic [TARGET_W-1:0]        wr_target;
    logic                       in_xfer;

    logic signed [ERR_W-1:0]    diff;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [INTEG_W-1:0]  integ_sat;
    logic [TARGET_W+7:0]        ff_prod;

    logic signed [GAIN_W:0]     mul_a;
    logic signed [INTEG_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [PROD_W-1:0]          prod_mag;

    logic signed [ACC_W-1:0]    quo_s;
    logic [DRIVE_W-1:0]         drive;

    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    // Configuration port
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign wr_target = (pwdata[TARGET_W-1:0] > TARGET_W'(TARGET_MAX))
                     ? TARGET_W'(TARGET_MAX) : pwdata[TARGET_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_TARGET: target_reg <= wr_target;
                REG_GAIN_P: gain_p_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_I: gain_i_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_D: gain_d_reg <= pwdata[GAIN_W-1:0];
                default:    target_reg <= target_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TARGET: prdata = {22'd0, target_reg};
            REG_GAIN_P: prdata = {16'd0, gain_p_reg};
            REG_GAIN_I: prdata = {16'd0, gain_i_reg};
            REG_GAIN_D: prdata = {16'd0, gain_d_reg};
            default:    prdata = '0;
        endcase
    end

    // Error, integral and feedforward
    assign diff      = $signed({9'd0, target_reg}) - $signed({2'd0, speed_reg});
    assign integ_sum = {integ_reg[INTEG_W-1], integ_reg} + (INTEG_W+1)'(diff);
    assign integ_sat = (integ_sum[INTEG_W] == integ_sum[INTEG_W-1])
                     ? integ_sum[INTEG_W-1:0]
                     : {integ_sum[INTEG_W], {(INTEG_W-1){~integ_sum[INTEG_W]}}};
    assign ff_prod   = 18'(target_reg) * 18'(FF_NUM);

    // Shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_MUL_P:
            begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = INTEG_W'(diff_reg);
            end
            ST_MUL_I:
            begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = integ_reg;
            end
            default:
            begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = INTEG_W'(dd_reg);
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // Shared divider
    always_comb
    begin
        div_req = '0;
        case (state_reg)
            ST_SPD_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(SPEED_NUM) << (DIV_W - SPEED_BITS);
                div_req.divisor  = (period_reg == '0) ? DIVISOR_W'(1) : period_reg;
                div_req.cycles   = SPEED_CYCLES;
            end
            ST_DIV_I_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_mag[INTEG_BITS-1:0];
                div_req.divisor  = DIVISOR_W'(INTEG_DIV);
                div_req.cycles   = INTEG_CYCLES;
            end
            ST_DIV_D_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {prod_mag[DERIV_BITS-1:0], (DIV_W-DERIV_BITS)'(0)};
                div_req.divisor  = DIVISOR_W'(DERIV_DIV);
                div_req.cycles   = DERIV_CYCLES;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    mspf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign quo_s = neg_reg ? -$signed(div_rsp.quotient[ACC_W-1:0])
                           : $signed(div_rsp.quotient[ACC_W-1:0]);

    always_comb
    begin
        if (acc_reg < 0)
        begin
            drive = '0;
        end
        else if (acc_reg > ACC_W'(DRIVE_MAX))
        begin
            drive = DRIVE_W'(DRIVE_MAX);
        end
        else
        begin
            drive = acc_reg[DRIVE_W-1:0];
        end
    end

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            period_reg  <= '0;
            speed_reg   <= '0;
            diff_reg    <= '0;
            dd_reg      <= '0;
            prev_reg    <= '0;
            integ_reg   <= '0;
            prod_reg    <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        period_reg <= s_axis_tdata;
                        speed_reg  <= '0;
                        acc_reg    <= '0;
                        if (target_reg == '0)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (s_axis_tuser)
                        begin
                            state_reg <= ST_SPD_GO;
                        end
                        else
                        begin
                            state_reg <= ST_ERR;
                        end
                    end
                end
                ST_SPD_GO:
                begin
                    state_reg <= ST_SPD_WAIT;
                end
                ST_SPD_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        speed_reg <= div_rsp.quotient[SPEED_W-1:0];
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR:
                begin
                    diff_reg  <= diff;
                    dd_reg    <= diff - prev_reg;
                    prev_reg  <= diff;
                    integ_reg <= integ_sat;
                    acc_reg   <= ACC_W'(ff_prod >> FF_SHIFT);
                    state_reg <= ST_MUL_P;
                end
                ST_MUL_P:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_I;
                end
                ST_MUL_I:
                begin
                    acc_reg   <= acc_reg + prod_reg[ACC_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_DIV_I_GO;
                end
                ST_DIV_I_GO:
                begin
                    neg_reg   <= prod_reg[PROD_W-1];
                    prod_reg  <= mul_p;
                    state_reg <= ST_DIV_I_WAIT;
                end
                ST_DIV_I_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg   <= acc_reg + quo_s;
                        state_reg <= ST_DIV_D_GO;
                    end
                end
                ST_DIV_D_GO:
                begin
                    neg_reg   <= prod_reg[PROD_W-1];
                    state_reg <= ST_DIV_D_WAIT;
                end
                ST_DIV_D_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg   <= acc_reg + quo_s;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_data_reg  <= {speed_reg, drive};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_data_reg};

endmodule

// File: rtl/mspf_checker.sv
// Port-level checks for the motor speed controller, bound to the top level.
`include "motor_speed_pid_feedforward_defines.svh"

module mspf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    `MSPF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
    `MSPF_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")
    `MSPF_ASSERT(a_drive_range, m_axis_tvalid |-> m_axis_tdata[8:0] <= 9'd400, "drive level above limit")
    `MSPF_ASSERT(a_speed_range, m_axis_tvalid |-> m_axis_tdata[25:9] <= 17'd129120 && m_axis_tdata[31:26] == 6'd0, "speed field out of range")
    `MSPF_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "result valid in reset")

endmodule

bind motor_speed_pid_feedforward mspf_checker u_mspf_checker (.*);
